>>> design/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL    = 3'd3,
        ST_ZERO    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DECIDE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PLACE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
    } res_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_stat_t;

endpackage

`default_nettype wire

>>> design/skt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink (input valid, input cmd, input key, output ready);
endinterface

`default_nettype wire

>>> design/skt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [8:0] position;
    logic [8:0] entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> design/skt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_ram
    import skt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [KEY_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> design/skt_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_seq
    import skt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire req_t      req,
    input  wire logic      res_load,
    output res_t           res,
    output seq_stat_t      stat
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             hit_reg, hit_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    status_t          status_reg, status_next;

    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [CNT_W-1:0] rd_addr;
    logic [KEY_W-1:0] rd_data;

    logic [CNT_W-1:0] mid;
    logic             search_more;
    logic             key_lt;
    logic             key_eq;
    logic             full;

    skt_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // shared probe compare and full flag
    assign mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign search_more = lo_reg < hi_reg;
    assign key_lt      = rd_data < key_reg;
    assign key_eq      = rd_data == key_reg;
    assign full        = held_reg >= CNT_W'(CAPACITY);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.cmd == CMD_INSERT && req.key == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                state_next = search_more ? S_CMP : S_DECIDE;
            end
            S_CMP:
            begin
                state_next = S_PROBE;
            end
            S_DECIDE:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_reg || full)
                        begin
                            state_next = S_DONE;
                        end
                        else if (held_reg > lo_reg)
                        begin
                            state_next = S_SHIFT_UP;
                        end
                        else
                        begin
                            state_next = S_PLACE;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_reg && (lo_reg + 1'b1 < held_reg))
                        begin
                            state_next = S_SHIFT_DN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                state_next = (idx_reg - 1'b1 > lo_reg) ? S_SHIFT_UP : S_PLACE;
            end
            S_SHIFT_DN:
            begin
                state_next = (idx_reg + 1'b1 < held_reg) ? S_SHIFT_DN : S_DONE;
            end
            S_PLACE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;
        rd_addr        = mid;
        stat.idle      = 1'b0;
        stat.res_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                stat.idle = 1'b1;
            end
            S_DECIDE:
            begin
                rd_addr = (cmd_reg == CMD_INSERT) ? held_reg - 1'b1 : lo_reg + 1'b1;
            end
            S_SHIFT_UP:
            begin
                wr_en   = 1'b1;
                rd_addr = idx_reg - CNT_W'(2);
            end
            S_SHIFT_DN:
            begin
                wr_en   = 1'b1;
                rd_addr = idx_reg + CNT_W'(2);
            end
            S_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = key_reg;
            end
            S_DONE:
            begin
                stat.res_valid = 1'b1;
            end
            default:
            begin
                rd_addr = mid;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        held_next   = held_reg;
        hit_next    = hit_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = req.cmd;
                    key_next    = req.key;
                    lo_next     = '0;
                    hi_next     = held_reg;
                    hit_next    = 1'b0;
                    status_next = ST_ZERO;
                end
            end
            S_CMP:
            begin
                if (key_lt)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next  = mid;
                    hit_next = key_eq;
                end
            end
            S_DECIDE:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        idx_next = held_reg;
                        if (hit_reg)
                        begin
                            status_next = ST_PRESENT;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_OK;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        idx_next = lo_reg;
                        if (hit_reg)
                        begin
                            held_next   = held_reg - 1'b1;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        status_next = hit_reg ? ST_OK : ST_ABSENT;
                    end
                endcase
            end
            S_SHIFT_UP:
            begin
                idx_next = idx_reg - 1'b1;
            end
            S_SHIFT_DN:
            begin
                idx_next = idx_reg + 1'b1;
            end
            S_PLACE:
            begin
                held_next = held_reg + 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        status_reg <= status_next;
    end

    assign res.status      = status_reg;
    assign res.position    = lo_reg;
    assign res.entry_count = held_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_CMP) |-> lo_reg <= hi_reg)
        else $error("search bounds crossed");

    a_place_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PLACE |=> held_reg == $past(held_reg) + 1'b1)
        else $error("insert did not grow the table");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("transfer accepted while busy");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> state_reg == S_DONE)
        else $error("result taken with none ready");
`endif

endmodule

`default_nettype wire

>>> design/sorted_key_table_unit.sv
// sorted key table: distinct 32-bit keys held in ascending order in a
// 256-entry single-port-write, single-port-read memory.
// request channel carries cmd (0 lookup, 1 insert, 2 remove, 3 as lookup)
// and key; response channel returns status, position and entry_count, one
// response per request transfer.
// one binary-search probe is a memory read (S_PROBE), then a compare
// (S_CMP); a search makes at most ceil(log2(n + 1)) probes for n held
// keys, and a zero-key insert skips the search. after the search, insert
// of a new key shifts each entry above the insert point up and then places
// the key; remove shifts each entry above the removed one down. the memory
// read/write port pair is the limit: one entry moves per cycle.
// one request is worked at a time; request.ready is high only when the
// sequencer is idle. a finished response sits in the output register and the
// next request is taken while it waits; a stalled receiver holds the response
// stable and the sequencer holds its next result until the register frees.
// reset empties the table at once (count to zero); memory contents are not
// cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_unit
    import skt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    skt_in_if.sink       request,
    skt_out_if.source    response
);

    logic      start;
    logic      res_load;
    req_t      req;
    res_t      res;
    seq_stat_t stat;

    logic      out_valid_reg, out_valid_next;
    res_t      out_res_reg;

    assign request.ready = stat.idle;
    assign start         = request.valid && stat.idle;
    assign req.cmd       = request.cmd;
    assign req.key       = request.key;

    assign res_load       = stat.res_valid && (!out_valid_reg || response.ready);
    assign out_valid_next = res_load || (out_valid_reg && !response.ready);

    skt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .res_load (res_load),
        .res      (res),
        .stat     (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= res;
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_res_reg.status;
    assign response.position    = out_res_reg.position;
    assign response.entry_count = out_res_reg.entry_count;

endmodule

`default_nettype wire
